[rtl/core/ncc_pkg.sv]
`default_nettype none

package ncc_pkg;

   localparam int COORD_W = 16;
   localparam int SLOT_W  = 5;
   localparam int INDEX_W = 5;
   localparam int COUNT_W = 6;
   localparam int SQ_W    = 32;
   localparam int DIST_W  = 33;

   localparam logic MODE_LOAD     = 1'b0;
   localparam logic MODE_CLASSIFY = 1'b1;

   // One item as it moves down the chain, with the running best match
   typedef struct packed {
      logic                       mode;
      logic [SLOT_W-1:0]          slot;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic [INDEX_W-1:0]         best_index;
      logic [DIST_W-1:0]          best_dist;
   } item_type;

endpackage

`default_nettype wire

[rtl/core/ncc_cell.sv]
`default_nettype none

module ncc_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic [ncc_pkg::COUNT_W-1:0]  active_count,
   input  wire logic                         in_valid,
   input  wire ncc_pkg::item_type            in_item,
   output      logic                         out_valid,
   output      ncc_pkg::item_type            out_item
);
   import ncc_pkg::*;

   localparam logic [6:0] CELL_NUM   = 7'(INDEX);
   localparam logic       FIRST_CELL = (INDEX == 0);

   // center held by this cell
   logic signed [COORD_W-1:0] center_x_ff;
   logic signed [COORD_W-1:0] center_y_ff;

   logic                      load_hit;
   logic signed [COORD_W:0]   dx;
   logic signed [COORD_W:0]   dy;
   logic signed [2*COORD_W+1:0] prod_x;
   logic signed [2*COORD_W+1:0] prod_y;

   logic                      mid_valid_ff;
   item_type                  mid_item_ff;
   logic [SQ_W-1:0]           sqx_ff;
   logic [SQ_W-1:0]           sqy_ff;

   logic [DIST_W-1:0]         sum_sq;
   logic                      cell_active;
   logic                      take;
   item_type                  out_item_in;

   logic                      out_valid_ff;
   item_type                  out_item_ff;

   assign load_hit = in_valid && (in_item.mode == MODE_LOAD)
                     && ({2'b00, in_item.slot} == CELL_NUM);

   assign dx     = {in_item.x[COORD_W-1], in_item.x} - {center_x_ff[COORD_W-1], center_x_ff};
   assign dy     = {in_item.y[COORD_W-1], in_item.y} - {center_y_ff[COORD_W-1], center_y_ff};
   assign prod_x = dx * dx;
   assign prod_y = dy * dy;

   assign sum_sq      = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign cell_active = CELL_NUM < {1'b0, active_count};
   assign take        = (mid_item_ff.mode == MODE_CLASSIFY) && cell_active
                        && (FIRST_CELL || (sum_sq < mid_item_ff.best_dist));

   always_comb begin
      out_item_in = mid_item_ff;
      if (take) begin
         out_item_in.best_index = INDEX_W'(INDEX);
         out_item_in.best_dist  = sum_sq;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_hit) begin
         center_x_ff <= in_item.x;
         center_y_ff <= in_item.y;
      end
      if (advance) begin
         mid_item_ff <= in_item;
         sqx_ff      <= prod_x[SQ_W-1:0];
         sqy_ff      <= prod_y[SQ_W-1:0];
         out_item_ff <= out_item_in;
      end
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         mid_valid_ff <= in_valid;
         out_valid_ff <= mid_valid_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

`default_nettype wire

[rtl/core/nearest_center_classifier_2d_top.sv]
`default_nettype none

// Channel   Direction  Ports
// req       in         req_valid, req_stall, req_mode, req_center_slot,
//                      req_x_coord, req_y_coord
// rsp       out        rsp_valid, rsp_stall, rsp_nearest_index
// csr       in         csr_write_enable, csr_write_data (active_centers)
//
// One item enters per cycle unless the chain is stalled; each cell spends two register
// stages on it (squares, then sum and compare), and a classify item passes both stages
// of every cell before rsp_valid rises. Load items ride the same chain,
// write their cell in order and drop at the tail without a result.
// Reset clears every stage valid bit and sets active_centers to 1.
// A stalled result freezes the whole chain and raises req_stall.

module nearest_center_classifier_2d_top #(
   parameter int MAX_CENTERS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic                                req_mode,
   input  wire logic [ncc_pkg::SLOT_W-1:0]          req_center_slot,
   input  wire logic signed [ncc_pkg::COORD_W-1:0]  req_x_coord,
   input  wire logic signed [ncc_pkg::COORD_W-1:0]  req_y_coord,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [ncc_pkg::INDEX_W-1:0]         rsp_nearest_index,
   input  wire logic                                csr_write_enable,
   input  wire logic [ncc_pkg::COUNT_W-1:0]         csr_write_data
);
   import ncc_pkg::*;

   logic [COUNT_W-1:0] active_ff;
   logic               advance;
   logic               link_valid [0:MAX_CENTERS];
   item_type           link_item  [0:MAX_CENTERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= COUNT_W'(1);
      end else if (csr_write_enable) begin
         active_ff <= csr_write_data;
      end
   end

   // hold everything while the tail result waits
   assign rsp_valid = link_valid[MAX_CENTERS] && (link_item[MAX_CENTERS].mode == MODE_CLASSIFY);
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign rsp_nearest_index = link_item[MAX_CENTERS].best_index;

   assign link_valid[0]           = req_valid;
   assign link_item[0].mode       = req_mode;
   assign link_item[0].slot       = req_center_slot;
   assign link_item[0].x          = req_x_coord;
   assign link_item[0].y          = req_y_coord;
   assign link_item[0].best_index = '0;
   assign link_item[0].best_dist  = '0;

   for (genvar i = 0; i < MAX_CENTERS; i++) begin : g_cell
      ncc_cell #(
         .INDEX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .active_count (active_ff),
         .in_valid     (link_valid[i]),
         .in_item      (link_item[i]),
         .out_valid    (link_valid[i+1]),
         .out_item     (link_item[i+1])
      );
   end

   a_index_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_nearest_index} < active_ff || rsp_nearest_index == '0))
      else $error("nearest index beyond active centers");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps

class nearest_center_predictor;

   localparam int TABLE_DEPTH = 32;

   logic signed [ncc_pkg::COORD_W-1:0] center_x_tab [TABLE_DEPTH];
   logic signed [ncc_pkg::COORD_W-1:0] center_y_tab [TABLE_DEPTH];
   logic [ncc_pkg::COUNT_W-1:0]        active_centers;
   logic [ncc_pkg::INDEX_W-1:0]        expected_index_q [$];
   int                                 error_count;

   function new();
      active_centers = 1;
      error_count    = 0;
   endfunction

   function void set_active(input logic [ncc_pkg::COUNT_W-1:0] value);
      active_centers = value;
   endfunction

   // Counts above the table depth use the whole table
   function int used_centers();
      return (active_centers > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_centers);
   endfunction

   function logic [ncc_pkg::INDEX_W-1:0] nearest(input logic signed [ncc_pkg::COORD_W-1:0] px,
                                                 input logic signed [ncc_pkg::COORD_W-1:0] py);
      longint dx;
      longint dy;
      longint sq_sum;
      longint best_dist;
      int     best;
      best      = 0;
      best_dist = 0;
      for (int i = 0; i < used_centers(); i++) begin
         dx     = longint'(px) - longint'(center_x_tab[i]);
         dy     = longint'(py) - longint'(center_y_tab[i]);
         sq_sum = dx * dx + dy * dy;
         // strict compare keeps the lowest index on a tie
         if (i == 0 || sq_sum < best_dist) begin
            best_dist = sq_sum;
            best      = i;
         end
      end
      return best[ncc_pkg::INDEX_W-1:0];
   endfunction

   function void take_item(input logic mode, input logic [ncc_pkg::SLOT_W-1:0] slot,
                           input logic signed [ncc_pkg::COORD_W-1:0] x,
                           input logic signed [ncc_pkg::COORD_W-1:0] y);
      if (mode == ncc_pkg::MODE_LOAD) begin
         if (slot < TABLE_DEPTH) begin
            center_x_tab[slot] = x;
            center_y_tab[slot] = y;
         end
      end else begin
         expected_index_q.push_back(nearest(x, y));
      end
   endfunction

   function void check_index(input logic [ncc_pkg::INDEX_W-1:0] actual);
      logic [ncc_pkg::INDEX_W-1:0] expected;
      if (expected_index_q.size() == 0) begin
         $display("%0t: nearest_index unexpected: expected none, actual %0d", $time, actual);
         error_count++;
      end else begin
         expected = expected_index_q.pop_front();
         if (actual !== expected) begin
            $display("%0t: nearest_index mismatch: expected %0d, actual %0d",
                     $time, expected, actual);
            error_count++;
         end
      end
   endfunction

   function int pending();
      return expected_index_q.size();
   endfunction

   function void flag_missing();
      foreach (expected_index_q[i]) begin
         $display("%0t: nearest_index missing: expected %0d, actual none",
                  $time, expected_index_q[i]);
         error_count++;
      end
   endfunction

endclass

module tb_top;

   import ncc_pkg::*;

   localparam int MAX_CENTERS  = 32;
   localparam int DRAIN_CYCLES = 2 * MAX_CENTERS + 8;
   localparam int STALL_LIMIT  = 5000;
   localparam int PHASE_ITEMS  = 62;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_mode = MODE_LOAD;
   logic [SLOT_W-1:0]         req_center_slot = '0;
   logic signed [COORD_W-1:0] req_x_coord = '0;
   logic signed [COORD_W-1:0] req_y_coord = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [INDEX_W-1:0]        rsp_nearest_index;
   logic                      csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]        csr_write_data = '0;

   nearest_center_predictor pred = new();

   bit          loaded [MAX_CENTERS];
   int          burst_left = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_hold = 0;
   int unsigned stall_style = 0;
   int unsigned stall_phase = 0;

   nearest_center_classifier_2d_top #(
      .MAX_CENTERS(MAX_CENTERS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_center_slot   (req_center_slot),
      .req_x_coord       (req_x_coord),
      .req_y_coord       (req_y_coord),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_nearest_index (rsp_nearest_index),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            pred.check_index(rsp_nearest_index);
         end
         if (req_valid && !req_stall) begin
            pred.take_item(req_mode, req_center_slot, req_x_coord, req_y_coord);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("FAIL");
      $finish;
   end

   // Receiver: switch between no stall, light, heavy and periodic stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_hold == 0) begin
            stall_hold  = $urandom_range(50, 300);
            stall_style = $urandom_range(0, 3);
            stall_phase = $urandom_range(2, 20);
         end
         stall_hold--;
         case (stall_style)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= ((stall_hold / stall_phase) % 2 == 1);
            end
         endcase
      end
   end

   function automatic int first_unloaded(input int count);
      for (int i = 0; i < count; i++) begin
         if (!loaded[i]) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic logic signed [COORD_W-1:0] edge_coord();
      case ($urandom_range(0, 3))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         default: return -16'sd1;
      endcase
   endfunction

   task automatic send_item(input logic mode, input logic [SLOT_W-1:0] slot,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_center_slot <= slot;
      req_x_coord     <= x;
      req_y_coord     <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (mode == MODE_LOAD) begin
         loaded[slot] = 1'b1;
      end
   endtask

   // Hold the sender until the chain is empty, then write the register
   task automatic write_active_centers(input logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pred.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pred.set_active(value);
   endtask

   task automatic random_item();
      int                        count;
      int                        missing;
      int                        slot;
      int                        k;
      int                        span;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      count   = pred.used_centers();
      missing = first_unloaded(count);
      x       = COORD_W'($urandom);
      y       = COORD_W'($urandom);
      if (missing >= 0 || $urandom_range(0, 99) < 35) begin
         // load: fill active gaps first so no classify reads an empty entry
         if (missing >= 0) begin
            slot = missing;
         end else if (count > 0 && $urandom_range(0, 9) < 7) begin
            slot = $urandom_range(0, count - 1);
         end else begin
            slot = $urandom_range(0, MAX_CENTERS - 1);
         end
         k = $urandom_range(0, MAX_CENTERS - 1);
         if ($urandom_range(0, 5) == 0 && loaded[k]) begin
            x = pred.center_x_tab[k];
            y = pred.center_y_tab[k];
         end else if ($urandom_range(0, 9) == 0) begin
            x = edge_coord();
            y = edge_coord();
         end
         send_item(MODE_LOAD, SLOT_W'(slot), x, y);
      end else begin
         if (count > 0 && $urandom_range(0, 1) == 0) begin
            k    = $urandom_range(0, count - 1);
            span = $urandom_range(1, 3000);
            x = COORD_W'(int'(pred.center_x_tab[k]) + int'($urandom_range(0, 2 * span)) - span);
            y = COORD_W'(int'(pred.center_y_tab[k]) + int'($urandom_range(0, 2 * span)) - span);
         end else if ($urandom_range(0, 9) == 0) begin
            x = edge_coord();
            y = edge_coord();
         end
         send_item(MODE_CLASSIFY, SLOT_W'($urandom), x, y);
      end
   endtask

   initial begin
      logic [COUNT_W-1:0] phase_counts [10];
      phase_counts = '{6'd0, 6'd32, 6'd63, 6'd5, 6'd33, 6'd1, 6'd17, 6'd2, 6'd31, 6'd9};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single center after reset
      send_item(MODE_LOAD, 5'd0, -16'sd32768, -16'sd32768);
      send_item(MODE_CLASSIFY, 5'd31, 16'sd32767, 16'sd32767);
      send_item(MODE_CLASSIFY, 5'd0, -16'sd32768, -16'sd32768);

      write_active_centers(6'd4);
      send_item(MODE_LOAD, 5'd1, 16'sd32767, 16'sd32767);
      send_item(MODE_LOAD, 5'd2, -16'sd32768, 16'sd32767);
      send_item(MODE_LOAD, 5'd3, 16'sd32767, -16'sd32768);
      send_item(MODE_LOAD, 5'd31, -16'sd1, -16'sd1);
      send_item(MODE_CLASSIFY, 5'd0, 16'sd0, 16'sd0);
      send_item(MODE_CLASSIFY, 5'd31, 16'sd32767, -16'sd32768);
      send_item(MODE_CLASSIFY, 5'd7, -16'sd32768, 16'sd32767);
      send_item(MODE_CLASSIFY, 5'd0, 16'sd32767, 16'sd32767);
      send_item(MODE_CLASSIFY, 5'd0, -16'sd1, 16'sd0);
      // duplicate centers: the tie must go to the lower slot
      send_item(MODE_LOAD, 5'd2, -16'sd32768, -16'sd32768);
      send_item(MODE_CLASSIFY, 5'd0, -16'sd32000, -16'sd32000);
      send_item(MODE_LOAD, 5'd3, 16'sd32767, 16'sd32767);
      send_item(MODE_CLASSIFY, 5'd0, 16'sd100, 16'sd100);
      // equal distance from two different centers
      send_item(MODE_LOAD, 5'd0, -16'sd10, 16'sd0);
      send_item(MODE_LOAD, 5'd1, 16'sd10, 16'sd0);
      send_item(MODE_CLASSIFY, 5'd0, 16'sd0, 16'sd5);

      foreach (phase_counts[p]) begin
         write_active_centers(phase_counts[p]);
         repeat (PHASE_ITEMS) random_item();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pred.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      pred.flag_missing();
      if (pred.error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
